### rtl/gcd_pkg.sv
// Shared constants, types and elaboration-time table functions for the distance block.
`default_nettype none

package gcd_pkg;

	localparam int CORDIC_STEPS_DEF    = 24;
	localparam int ANGLE_FRAC_BITS_DEF = 28;

	localparam int LAT_W    = 31;
	localparam int LON_W    = 32;
	localparam int DIST_W   = 25;
	localparam int H_W      = 34;   // signed angle in 5e-8 degree units
	localparam int M_W      = 33;   // angle folded into one turn
	localparam int REM_W    = 31;   // remainder below a quarter turn
	localparam int RAD_W    = 33;
	localparam int ONE_W    = 63;   // Q62 values in [0, 1]
	localparam int SQ_W     = 64;
	localparam int SQ_STEPS = 32;
	localparam int SQ_OUT_W = 32;
	localparam int VEC_W    = 35;
	localparam int DIAM_W   = 24;

	localparam logic [63:0] PI_Q62        = 64'hC90F_DAA2_2168_C235;
	localparam logic [63:0] TURN_H        = 64'd7200000000;
	localparam logic [63:0] QUARTER_H     = 64'd1800000000;
	localparam logic [63:0] RAD_PER_H_Q63 = (PI_Q62 + (QUARTER_H >> 1)) / QUARTER_H;
	localparam logic [63:0] ONE_Q62       = 64'd1 << 62;
	localparam logic [63:0] DIAMETER_M    = 64'd12742000;
	localparam logic [DIST_W-1:0] MAX_DIST = 25'd20015087;

	typedef enum logic [1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} quad_t;

	// shift-subtract quotient, used only while building constant tables
	function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], num[b]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
		input int s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p + (128'd1 << (s - 1));
		return 64'(p >> s);
	endfunction

	function automatic logic [63:0] q62_to_f(input logic [63:0] v, input int f);
		return (v + (64'd1 << (61 - f))) >> (62 - f);
	endfunction

	function automatic logic [63:0] atan_q62(input int i);
		logic signed [63:0] acc;
		logic [63:0] t;
		int e;
		logic done;
		acc  = '0;
		done = 1'b0;
		if (i == 0) return PI_Q62 >> 2;
		for (int k = 0; k < 32; k++) begin
			e = i * (2 * k + 1);
			if (e > 62) done = 1'b1;
			if (!done) begin
				t = long_div(64'd1 << (62 - e), 64'(2 * k + 1));
				if (k[0]) acc = acc - $signed(t);
				else acc = acc + $signed(t);
			end
		end
		return acc;
	endfunction

	function automatic logic [63:0] atan_f(input int i, input int f);
		return q62_to_f(atan_q62(i), f);
	endfunction

	// inverse CORDIC gain by Newton steps on 1/sqrt(prod)
	function automatic logic [63:0] gain_f(input int n, input int f);
		logic [63:0] p;
		logic [63:0] r;
		logic [63:0] t;
		logic [63:0] u;
		p = 64'd1 << 60;
		r = 64'd2767011611056432742;
		for (int i = 0; i < 32; i++) begin
			if (i < n) p = p + (p >> (2 * i));
		end
		for (int k = 0; k < 6; k++) begin
			t = mul_shr(r, r, 62);
			u = mul_shr(p, t, 60);
			r = mul_shr(r, (ONE_Q62 << 1) + ONE_Q62 - u, 63);
		end
		return q62_to_f(r, f);
	endfunction

endpackage

`default_nettype wire

### rtl/great_circle_distance.sv
// Haversine great-circle distance pipeline, top level.
//
//   channel | signals                                  | dir | beat
//   --------+------------------------------------------+-----+---------------------
//   in      | in_valid in_ready source_/target_ lat/lon | in  | one point pair
//   out     | out_valid out_ready distance_meters       | out | one distance, meters
//
// One beat per cycle in and out while the skid register is empty; the pipeline
// depth is set by the two CORDIC cell rows and the 32-cell square-root row.
// Reset clears only the valid bits of the pipeline and of the two output registers.
// The output register and a skid register hold results; the pipeline holds
// while both are full, and in_ready stays low until the skid register drains.
`default_nettype none

module great_circle_distance #(
	parameter int CORDIC_STEPS    = gcd_pkg::CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [gcd_pkg::LAT_W-1:0]   source_latitude,
	input  logic signed [gcd_pkg::LON_W-1:0]   source_longitude,
	input  logic signed [gcd_pkg::LAT_W-1:0]   target_latitude,
	input  logic signed [gcd_pkg::LON_W-1:0]   target_longitude,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [gcd_pkg::DIST_W-1:0]         distance_meters
);

	localparam int N     = CORDIC_STEPS;
	localparam int F     = ANGLE_FRAC_BITS;
	localparam int WR    = F + 3;
	localparam int ZW    = F + 3;
	localparam int MW    = F + 2;
	localparam int PW    = 2 * MW;
	localparam int PS    = 2 * F - 62;
	localparam int ZC_W  = F + 2;
	localparam int FP_W  = ZC_W + gcd_pkg::DIAM_W;
	localparam int LAT   = 45 + 2 * N;
	localparam int H_W   = gcd_pkg::H_W;
	localparam int M_W   = gcd_pkg::M_W;
	localparam int REM_W = gcd_pkg::REM_W;
	localparam int ONE_W = gcd_pkg::ONE_W;
	localparam int SQ_W  = gcd_pkg::SQ_W;
	localparam int SQN   = gcd_pkg::SQ_STEPS;
	localparam int VW    = gcd_pkg::VEC_W;
	localparam int DW    = gcd_pkg::DIST_W;

	localparam logic signed [H_W-1:0] TURN_S  = H_W'(gcd_pkg::TURN_H);
	localparam logic [M_W-1:0]        Q1      = M_W'(gcd_pkg::QUARTER_H);
	localparam logic [M_W-1:0]        Q2      = M_W'(gcd_pkg::QUARTER_H * 2);
	localparam logic [M_W-1:0]        Q3      = M_W'(gcd_pkg::QUARTER_H * 3);
	localparam logic signed [WR-1:0]  GAIN    = WR'(gcd_pkg::gain_f(N, F));
	localparam logic [ONE_W-1:0]      ONE     = ONE_W'(gcd_pkg::ONE_Q62);

	logic en, push, pop;
	logic out_valid_q, skid_valid_q;
	logic [DW-1:0] out_q, skid_q;
	logic [LAT-1:0] vld_q;

	logic signed [H_W-1:0] h [4];
	logic [M_W-1:0] m_s1 [4];
	logic [REM_W-1:0] rem_s2 [4];
	gcd_pkg::quad_t quad_s2 [4];
	gcd_pkg::quad_t quad_pipe_q [4][N+2];
	logic [REM_W+gcd_pkg::RAD_W-1:0] zp [4];
	logic signed [WR-1:0] rx [4][N+1];
	logic signed [WR-1:0] ry [4][N+1];
	logic signed [ZW-1:0] rz [4][N+1];
	logic signed [WR-1:0] val [4];
	logic [MW-1:0] mag_s3 [4];
	logic neg_s3;

	logic [PW-1:0] pp [3];
	logic [ONE_W-1:0] prod_n [3];
	logic [ONE_W-1:0] prod_s4 [3];
	logic neg_pipe_q [2];
	logic neg_s4;

	logic [2*ONE_W-1:0] tp;
	logic [ONE_W-1:0] sp2_pipe_q [2];
	logic negt_pipe_q [2];
	logic [63:0] t_rnd;
	logic [ONE_W-1:0] a_n, a_s5;

	logic [SQ_W-1:0] sv [2][SQN+1];
	logic [SQ_W-1:0] sr [2][SQN+1];
	logic signed [VW-1:0] vx [N+1];
	logic signed [VW-1:0] vy [N+1];
	logic signed [ZW-1:0] vz [N+1];

	logic [ZC_W-1:0] zc;
	logic [FP_W-1:0] fp;
	logic [FP_W:0] frnd;
	logic [FP_W-F:0] dist_full;
	logic [DW-1:0] dist_n;

	assign en       = !skid_valid_q;
	assign in_ready = en;
	assign push     = en && vld_q[LAT-1];
	assign pop      = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// angles in half units, folded into one turn
	always_comb begin
		h[0] = H_W'(source_latitude) <<< 1;
		h[1] = H_W'(target_latitude) <<< 1;
		h[2] = H_W'(target_latitude) - H_W'(source_latitude);
		h[3] = H_W'(target_longitude) - H_W'(source_longitude);
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		logic signed [H_W-1:0] hm;
		logic [64:0] z65;
		gcd_pkg::quad_t qd;

		assign hm = (h[l] < 0) ? h[l] + TURN_S : h[l];

		always_ff @(posedge clk) begin
			if (en) begin
				m_s1[l] <= M_W'(hm);
				priority if (m_s1[l] >= Q3) begin
					quad_s2[l] <= gcd_pkg::QUAD_IV;
					rem_s2[l]  <= REM_W'(m_s1[l] - Q3);
				end else if (m_s1[l] >= Q2) begin
					quad_s2[l] <= gcd_pkg::QUAD_III;
					rem_s2[l]  <= REM_W'(m_s1[l] - Q2);
				end else if (m_s1[l] >= Q1) begin
					quad_s2[l] <= gcd_pkg::QUAD_II;
					rem_s2[l]  <= REM_W'(m_s1[l] - Q1);
				end else begin
					quad_s2[l] <= gcd_pkg::QUAD_I;
					rem_s2[l]  <= m_s1[l][REM_W-1:0];
				end
				quad_pipe_q[l][0] <= quad_s2[l];
				for (int j = 1; j < N + 2; j++) quad_pipe_q[l][j] <= quad_pipe_q[l][j-1];
			end
		end

		gcd_mul #(.WA(REM_W), .WB(gcd_pkg::RAD_W)) u_rad (
			.clk (clk),
			.en  (en),
			.a_i (rem_s2[l]),
			.b_i (gcd_pkg::RAD_W'(gcd_pkg::RAD_PER_H_Q63)),
			.p_o (zp[l])
		);

		assign z65      = {1'b0, zp[l]} + (65'(1) << (62 - F));
		assign rx[l][0] = GAIN;
		assign ry[l][0] = '0;
		assign rz[l][0] = $signed(ZW'(z65 >> (63 - F)));

		for (genvar i = 0; i < N; i++) begin : g_rot
			gcd_cordic_cell #(
				.W(WR), .ZW(ZW), .F(F), .STEP(i), .VECTORING(1'b0)
			) u_cell (
				.clk (clk),
				.en  (en),
				.x_i (rx[l][i]),
				.y_i (ry[l][i]),
				.z_i (rz[l][i]),
				.x_o (rx[l][i+1]),
				.y_o (ry[l][i+1]),
				.z_o (rz[l][i+1])
			);
		end

		// map back by quadrant: latitudes want cosine, differences want sine
		assign qd = quad_pipe_q[l][N+1];
		always_comb begin
			unique case (qd)
				gcd_pkg::QUAD_I:   val[l] = (l < 2) ? rx[l][N] : ry[l][N];
				gcd_pkg::QUAD_II:  val[l] = (l < 2) ? -ry[l][N] : rx[l][N];
				gcd_pkg::QUAD_III: val[l] = (l < 2) ? -rx[l][N] : -ry[l][N];
				gcd_pkg::QUAD_IV:  val[l] = (l < 2) ? ry[l][N] : -rx[l][N];
				default:           val[l] = '0;
			endcase
		end

		always_ff @(posedge clk) begin
			if (en) mag_s3[l] <= MW'((val[l] < 0) ? -val[l] : val[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3        <= val[0][WR-1] ^ val[1][WR-1];
			neg_pipe_q[0] <= neg_s3;
			neg_pipe_q[1] <= neg_pipe_q[0];
			neg_s4        <= neg_pipe_q[1];
		end
	end

	// sin^2(dlat/2), sin^2(dlon/2), cos(lat1)cos(lat2) in Q62, clamped to one
	for (genvar k = 0; k < 3; k++) begin : g_prod
		logic [65:0] r66;

		gcd_mul #(.WA(MW), .WB(MW)) u_sq (
			.clk (clk),
			.en  (en),
			.a_i (mag_s3[(k == 2) ? 0 : k + 2]),
			.b_i (mag_s3[(k == 2) ? 1 : k + 2]),
			.p_o (pp[k])
		);

		if (PS > 0) begin : g_down
			logic [PW:0] rnd;
			assign rnd = {1'b0, pp[k]} + ((PW+1)'(1) << (PS - 1));
			assign r66 = 66'(rnd >> PS);
		end else begin : g_up
			assign r66 = 66'(pp[k]) << (-PS);
		end

		assign prod_n[k] = (r66 > 66'(ONE)) ? ONE : r66[ONE_W-1:0];

		always_ff @(posedge clk) begin
			if (en) prod_s4[k] <= prod_n[k];
		end
	end

	gcd_mul #(.WA(ONE_W), .WB(ONE_W)) u_term (
		.clk (clk),
		.en  (en),
		.a_i (prod_s4[2]),
		.b_i (prod_s4[1]),
		.p_o (tp)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sp2_pipe_q[0]  <= prod_s4[0];
			sp2_pipe_q[1]  <= sp2_pipe_q[0];
			negt_pipe_q[0] <= neg_s4;
			negt_pipe_q[1] <= negt_pipe_q[0];
			a_s5           <= a_n;
		end
	end

	always_comb begin
		t_rnd = 64'((tp + ((2*ONE_W)'(1) << 61)) >> 62);
		if (!negt_pipe_q[1]) begin
			a_n = (t_rnd > 64'(ONE - sp2_pipe_q[1])) ? ONE : ONE_W'(64'(sp2_pipe_q[1]) + t_rnd);
		end else begin
			a_n = (t_rnd > 64'(sp2_pipe_q[1])) ? '0 : ONE_W'(64'(sp2_pipe_q[1]) - t_rnd);
		end
	end

	// square roots of a and of 1-a, one result bit per cell
	assign sv[0][0] = SQ_W'(a_s5);
	assign sv[1][0] = SQ_W'(ONE - a_s5);
	assign sr[0][0] = '0;
	assign sr[1][0] = '0;

	for (genvar s = 0; s < 2; s++) begin : g_sq_lane
		for (genvar k = 0; k < SQN; k++) begin : g_sq
			gcd_sqrt_cell #(.K(k)) u_cell (
				.clk (clk),
				.en  (en),
				.v_i (sv[s][k]),
				.r_i (sr[s][k]),
				.v_o (sv[s][k+1]),
				.r_o (sr[s][k+1])
			);
		end
	end

	assign vx[0] = $signed({{(VW-gcd_pkg::SQ_OUT_W){1'b0}}, sr[1][SQN][gcd_pkg::SQ_OUT_W-1:0]});
	assign vy[0] = $signed({{(VW-gcd_pkg::SQ_OUT_W){1'b0}}, sr[0][SQN][gcd_pkg::SQ_OUT_W-1:0]});
	assign vz[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_vec
		gcd_cordic_cell #(
			.W(VW), .ZW(ZW), .F(F), .STEP(i), .VECTORING(1'b1)
		) u_cell (
			.clk (clk),
			.en  (en),
			.x_i (vx[i]),
			.y_i (vy[i]),
			.z_i (vz[i]),
			.x_o (vx[i+1]),
			.y_o (vy[i+1]),
			.z_o (vz[i+1])
		);
	end

	// drop a negative central angle to zero
	assign zc = vz[N][ZW-1] ? '0 : vz[N][ZC_W-1:0];

	gcd_mul #(.WA(ZC_W), .WB(gcd_pkg::DIAM_W)) u_dist (
		.clk (clk),
		.en  (en),
		.a_i (zc),
		.b_i (gcd_pkg::DIAM_W'(gcd_pkg::DIAMETER_M)),
		.p_o (fp)
	);

	always_comb begin
		frnd      = {1'b0, fp} + ((FP_W+1)'(1) << (F - 1));
		dist_full = (FP_W-F+1)'(frnd >> F);
		dist_n    = (dist_full > (FP_W-F+1)'(gcd_pkg::MAX_DIST)) ? gcd_pkg::MAX_DIST
			: dist_full[DW-1:0];
	end

	// output register plus skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) skid_valid_q <= 1'b0;
		end else if (out_valid_q) begin
			if (push && !pop) skid_valid_q <= 1'b1;
			else if (!push && pop) out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) out_q <= skid_q;
		end else if (out_valid_q) begin
			if (push && pop) out_q <= dist_n;
			else if (push) skid_q <= dist_n;
		end else if (push) begin
			out_q <= dist_n;
		end
	end

	assign out_valid       = out_valid_q;
	assign distance_meters = out_q;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a beat while the output register is empty");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (distance_meters <= gcd_pkg::MAX_DIST))
		else $error("distance above half circumference");

	a_skid_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_valid_q && !out_ready) |=> (skid_valid_q && skid_q == $past(dist_n)))
		else $error("result lost while output stalled");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && skid_valid_q) |=> (out_valid_q && distance_meters == $past(skid_q)))
		else $error("skid beat not moved to output");

endmodule

`default_nettype wire

### rtl/gcd_mul.sv
// Two-stage unsigned multiplier: split partial products, then their sum.
`default_nettype none

module gcd_mul #(
	parameter int WA = 32,
	parameter int WB = 32
) (
	input  logic               clk,
	input  logic               en,
	input  logic [WA-1:0]      a_i,
	input  logic [WB-1:0]      b_i,
	output logic [WA+WB-1:0]   p_o
);

	localparam int LA = WA / 2;
	localparam int HA = WA - LA;
	localparam int LB = WB / 2;
	localparam int HB = WB - LB;
	localparam int PW = WA + WB;

	logic [LA+LB-1:0] pp_ll_s1;
	logic [LA+HB-1:0] pp_lh_s1;
	logic [HA+LB-1:0] pp_hl_s1;
	logic [HA+HB-1:0] pp_hh_s1;
	logic [PW-1:0]    p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_ll_s1 <= (LA+LB)'(a_i[LA-1:0]) * (LA+LB)'(b_i[LB-1:0]);
			pp_lh_s1 <= (LA+HB)'(a_i[LA-1:0]) * (LA+HB)'(b_i[WB-1:LB]);
			pp_hl_s1 <= (HA+LB)'(a_i[WA-1:LA]) * (HA+LB)'(b_i[LB-1:0]);
			pp_hh_s1 <= (HA+HB)'(a_i[WA-1:LA]) * (HA+HB)'(b_i[WB-1:LB]);
			p_s2     <= PW'(pp_ll_s1) + (PW'(pp_lh_s1) << LB) + (PW'(pp_hl_s1) << LA)
				+ (PW'(pp_hh_s1) << (LA + LB));
		end
	end

	assign p_o = p_s2;

endmodule

`default_nettype wire

### rtl/gcd_cordic_cell.sv
// One CORDIC micro-rotation, rotation or vectoring mode, registered.
`default_nettype none

module gcd_cordic_cell #(
	parameter int W         = 31,
	parameter int ZW        = 31,
	parameter int F         = 28,
	parameter int STEP      = 0,
	parameter bit VECTORING = 1'b0
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [W-1:0]  x_i,
	input  logic signed [W-1:0]  y_i,
	input  logic signed [ZW-1:0] z_i,
	output logic signed [W-1:0]  x_o,
	output logic signed [W-1:0]  y_o,
	output logic signed [ZW-1:0] z_o
);

	localparam logic signed [ZW-1:0] ATAN = ZW'(gcd_pkg::atan_f(STEP, F));

	logic signed [W-1:0]  xs, ys;
	logic signed [W-1:0]  x_n, y_n;
	logic signed [ZW-1:0] z_n;
	logic                 ccw, cw;
	logic signed [W-1:0]  x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;

	always_comb begin
		xs  = x_i >>> STEP;
		ys  = y_i >>> STEP;
		ccw = VECTORING ? (y_i < 0) : (z_i > 0);
		cw  = VECTORING ? (y_i > 0) : (z_i < 0);
		x_n = x_i;
		y_n = y_i;
		z_n = z_i;
		// zero residual: hold the vector
		if (ccw) begin
			x_n = x_i - ys;
			y_n = y_i + xs;
			z_n = z_i - ATAN;
		end else if (cw) begin
			x_n = x_i + ys;
			y_n = y_i - xs;
			z_n = z_i + ATAN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_n;
			y_s1 <= y_n;
			z_s1 <= z_n;
		end
	end

	assign x_o = x_s1;
	assign y_o = y_s1;
	assign z_o = z_s1;

endmodule

`default_nettype wire

### rtl/gcd_sqrt_cell.sv
// One digit of the bitwise integer square root, registered.
`default_nettype none

module gcd_sqrt_cell #(
	parameter int K = 0
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [gcd_pkg::SQ_W-1:0]    v_i,
	input  logic [gcd_pkg::SQ_W-1:0]    r_i,
	output logic [gcd_pkg::SQ_W-1:0]    v_o,
	output logic [gcd_pkg::SQ_W-1:0]    r_o
);

	localparam logic [gcd_pkg::SQ_W-1:0] BIT = gcd_pkg::SQ_W'(1) << (62 - 2 * K);

	logic [gcd_pkg::SQ_W-1:0] trial, v_n, r_n;
	logic [gcd_pkg::SQ_W-1:0] v_s1, r_s1;

	always_comb begin
		trial = r_i + BIT;
		if (v_i >= trial) begin
			v_n = v_i - trial;
			r_n = (r_i >> 1) + BIT;
		end else begin
			v_n = v_i;
			r_n = r_i >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1 <= v_n;
			r_s1 <= r_n;
		end
	end

	assign v_o = v_s1;
	assign r_o = r_s1;

endmodule

`default_nettype wire
